### sv/fmp4h_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmp4h_pkg
// Shared types, constants and the header word table for the fragment
// header generator.
// ---------------------------------------------------------------------------
package fmp4h_pkg;

	localparam int NumWords      = 26;
	localparam int WordIdxW      = 5;
	localparam int QueueDepthDef = 2;

	localparam int PtsW      = 41;
	localparam int RawW      = 40;
	localparam int RateW     = 18;
	localparam int ProdW     = RawW + RateW;
	localparam int SplitW    = 30;
	localparam int HiW       = ProdW - SplitW;
	localparam int YW        = 38;
	localparam int ZW        = 31;
	localparam int RecipW    = ZW + 32;
	localparam int RecipShift = 41;
	localparam int QcW       = RecipW - RecipShift;
	localparam int DivSteps  = 3;
	localparam int StepW     = 2;
	localparam int TickW     = 48;
	localparam int DurRegW   = 17;

	// 2^30 = 1000 * SplitQuot + SplitRem; MsRecip = ceil(2^41 / 1000)
	localparam logic [20:0]      SplitQuot       = 21'd1073741;
	localparam logic [9:0]       SplitRem        = 10'd824;
	localparam logic [31:0]      MsRecip         = 32'd2199023256;
	localparam logic [RateW-1:0] VideoTimescale  = RateW'(90000);
	localparam logic [31:0]      VideoFallbackDur = 32'(90000 / 30);
	localparam logic [31:0]      AudioDefaultDur  = 32'd1024;
	localparam logic [31:0]      FlagsKey        = 32'h0200_0000;
	localparam logic [31:0]      FlagsNonKey     = 32'h0101_0000;
	localparam logic [31:0]      FlagsAudio      = 32'h0000_0000;

	typedef enum logic [1:0] {
		REG_AUDIO_ENABLE = 2'd0,
		REG_AUDIO_RATE   = 2'd1,
		REG_VIDEO_DUR    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic               audio_enable;
		logic [RateW-1:0]   audio_rate;
		logic [DurRegW-1:0] video_dur;
	} cfg_t;

	typedef struct packed {
		logic        trk;
		logic [31:0] seq;
		logic [31:0] tfdt;
		logic [31:0] dur;
		logic [31:0] size;
		logic [31:0] flags;
	} frag_entry_t;

	function automatic logic [31:0] frag_word(input frag_entry_t e,
		input logic [WordIdxW-1:0] idx);
		logic [31:0] w;
		case (idx)
			5'd0:  w = 32'd96;
			5'd1:  w = 32'h6D6F_6F66; // moof
			5'd2:  w = 32'd16;
			5'd3:  w = 32'h6D66_6864; // mfhd
			5'd4:  w = 32'd0;
			5'd5:  w = e.seq;
			5'd6:  w = 32'd72;
			5'd7:  w = 32'h7472_6166; // traf
			5'd8:  w = 32'd16;
			5'd9:  w = 32'h7466_6864; // tfhd
			5'd10: w = 32'h0002_0000;
			5'd11: w = e.trk ? 32'd2 : 32'd1;
			5'd12: w = 32'd16;
			5'd13: w = 32'h7466_6474; // tfdt
			5'd14: w = 32'd0;
			5'd15: w = e.tfdt;
			5'd16: w = 32'd32;
			5'd17: w = 32'h7472_756E; // trun
			5'd18: w = 32'h0000_0701;
			5'd19: w = 32'd1;
			5'd20: w = 32'd104;
			5'd21: w = e.dur;
			5'd22: w = e.size;
			5'd23: w = e.flags;
			5'd24: w = e.size + 32'd8;
			5'd25: w = 32'h6D64_6174; // mdat
			default: w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

### sv/fmp4h_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmp4h_front
// Accepts sample descriptors, drops empty and disabled-audio samples,
// converts ms to track ticks (multiply, then a three-step reciprocal divide
// by 1000) and works out the sample duration from the per-track history.
// ---------------------------------------------------------------------------
module fmp4h_front import fmp4h_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               mode,
	input  logic signed [PtsW-1:0] pts_ms,
	input  logic [31:0]        payload_len,
	input  logic               is_key,
	output logic               push,
	input  logic               push_ready,
	output frag_entry_t        push_entry
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t          state_q;
	logic             buf_vld_q;
	logic             buf_trk_q;
	logic [RawW-1:0]  buf_raw_q;
	logic [31:0]      buf_size_q;
	logic             buf_key_q;

	logic             wk_trk_q;
	logic [31:0]      wk_size_q;
	logic             wk_key_q;
	logic [ProdW-1:0] prod_q;
	logic [TickW-1:0] quo_q;
	logic [YW-1:0]    rem_q;
	logic [StepW-1:0] step_q;

	logic [31:0]      seq_q;
	logic [TickW-1:0] last_ts_q [2];
	logic [1:0]       seen_q;

	logic             accept;
	logic             drop;
	logic             start;
	logic [RateW-1:0] ts_sel;
	logic [ProdW-1:0] prod;
	logic [HiW-1:0]   fold_hi;
	logic [SplitW-1:0] fold_lo;
	logic [TickW-1:0] fold_quo;
	logic [YW-1:0]    fold_rem;
	logic [RecipW-1:0] recip;
	logic [TickW-1:0] ticks;
	logic [TickW-1:0] last_ts;
	logic [TickW-1:0] delta;
	logic [31:0]      dur;

	assign item_ready = !buf_vld_q;
	assign accept     = item_valid && item_ready;
	assign drop       = (payload_len == 32'd0) || (mode && !cfg.audio_enable);
	assign start      = (state_q == F_IDLE) && buf_vld_q;

	assign ts_sel = buf_trk_q ? cfg.audio_rate : VideoTimescale;
	assign prod   = {{RateW{1'b0}}, buf_raw_q} * {{RawW{1'b0}}, ts_sel};

	// P = hi * 2^30 + lo and 2^30 = 1000 * SplitQuot + SplitRem, so
	// P / 1000 = hi * SplitQuot + (hi * SplitRem + lo) / 1000. Two folds
	// leave under 2^31, which the reciprocal multiply finishes exactly.
	assign fold_hi  = (step_q == '0) ? prod_q[ProdW-1:SplitW]
		: {{(HiW-(YW-SplitW)){1'b0}}, rem_q[YW-1:SplitW]};
	assign fold_lo  = (step_q == '0) ? prod_q[SplitW-1:0] : rem_q[SplitW-1:0];
	assign fold_quo = {{(TickW-HiW){1'b0}}, fold_hi} * TickW'(SplitQuot);
	assign fold_rem = {{(YW-HiW){1'b0}}, fold_hi} * YW'(SplitRem)
		+ {{(YW-SplitW){1'b0}}, fold_lo};
	assign recip    = {{(RecipW-ZW){1'b0}}, rem_q[ZW-1:0]}
		* {{(RecipW-32){1'b0}}, MsRecip};

	assign ticks   = quo_q;
	assign last_ts = last_ts_q[wk_trk_q];
	assign delta   = ticks - last_ts;

	always_comb begin
		if (seen_q[wk_trk_q] && (ticks > last_ts))
			dur = (|delta[TickW-1:32]) ? 32'hFFFF_FFFF : delta[31:0];
		else if (wk_trk_q)
			dur = AudioDefaultDur;
		else if (cfg.video_dur != '0)
			dur = 32'(cfg.video_dur);
		else
			dur = VideoFallbackDur;
	end

	assign push = (state_q == F_PUSH);
	always_comb begin
		push_entry.trk   = wk_trk_q;
		push_entry.seq   = seq_q;
		push_entry.tfdt  = ticks[31:0];
		push_entry.dur   = dur;
		push_entry.size  = wk_size_q;
		push_entry.flags = wk_trk_q ? FlagsAudio : (wk_key_q ? FlagsKey : FlagsNonKey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			buf_vld_q <= 1'b0;
			step_q    <= '0;
			seq_q     <= 32'd1;
			seen_q    <= '0;
			last_ts_q[0] <= '0;
			last_ts_q[1] <= '0;
		end else begin
			if (accept && !drop)
				buf_vld_q <= 1'b1;
			else if (start)
				buf_vld_q <= 1'b0;

			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_DIV;
						step_q  <= '0;
					end
				end
				F_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == StepW'(DivSteps - 1))
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q             <= F_IDLE;
						seq_q               <= seq_q + 32'd1;
						last_ts_q[wk_trk_q] <= ticks;
						seen_q[wk_trk_q]    <= 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !drop) begin
			buf_trk_q  <= mode;
			buf_raw_q  <= pts_ms[PtsW-1] ? '0 : pts_ms[RawW-1:0];
			buf_size_q <= payload_len;
			buf_key_q  <= is_key;
		end
		if (start) begin
			wk_trk_q  <= buf_trk_q;
			wk_size_q <= buf_size_q;
			wk_key_q  <= buf_key_q;
			prod_q    <= prod;
		end else if (state_q == F_DIV) begin
			if (step_q == StepW'(DivSteps - 1)) begin
				quo_q <= quo_q + {{(TickW-QcW){1'b0}}, recip[RecipW-1:RecipShift]};
			end else begin
				quo_q <= (step_q == '0) ? fold_quo : quo_q + fold_quo;
				rem_q <= fold_rem;
			end
		end
	end

endmodule

### sv/fmp4h_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmp4h_queue
// Small FIFO of prepared fragment entries between the front and the
// word emitter.
// ---------------------------------------------------------------------------
module fmp4h_queue import fmp4h_pkg::*; #(
	parameter int DEPTH = QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        push_ready,
	input  frag_entry_t push_entry,
	output logic        pop_valid,
	input  logic        pop,
	output frag_entry_t pop_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frag_entry_t    mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

### sv/fmp4h_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmp4h_back
// Walks the 26 header words of each queued entry into a registered
// output stage, one word per cycle when the sink keeps up.
// ---------------------------------------------------------------------------
module fmp4h_back import fmp4h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  frag_entry_t q_entry,
	output logic        q_pop,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [31:0] header_word,
	output logic        last_word
);

	frag_entry_t         cur_q;
	logic                busy_q;
	logic [WordIdxW-1:0] cnt_q;
	logic                out_vld_q;
	logic [31:0]         out_word_q;
	logic                out_last_q;

	logic adv;
	logic load;
	logic last_now;

	assign adv      = !out_vld_q || word_ready;
	assign load     = busy_q && adv;
	assign last_now = (cnt_q == WordIdxW'(NumWords - 1));
	// next entry is picked up while its predecessor's final word is loaded into the output register
	assign q_pop    = q_valid && (!busy_q || (load && last_now));

	assign word_valid  = out_vld_q;
	assign header_word = out_word_q;
	assign last_word   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv)
				out_vld_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load) begin
				if (last_now)
					busy_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_entry;
		if (load) begin
			out_word_q <= frag_word(cur_q, cnt_q);
			out_last_q <= last_now;
		end
	end

endmodule

### sv/fmp4_fragment_header_gen.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fmp4_fragment_header_gen
// Writes a single-sample moof box plus mdat header for each sample.
// ---------------------------------------------------------------------------
// Usage: program audio_enable, audio_sample_rate and video_default_duration
// over the APB port (0x0, 0x4, 0x8) while no transaction is in flight.
// Each sample descriptor (mode, pts_ms, payload_len, is_key) enters on the
// item channel; empty samples and audio samples with audio off are taken
// and dropped. Every kept sample yields 26 words on the word channel, the
// last flagged by last_word.
// Path: an accepted sample passes the input buffer, the product register,
// the divide by 1000 in the front, the queue, the emitter's entry register
// and its output register. Throughput: one word per cycle while the sink
// keeps up, set by the word emitter; the front converts the next sample
// meanwhile; a queue of QUEUE_DEPTH entries (two by default) holds them.
// Reset clears the sequence number to 1, the per-track timestamp history
// and the registers. If the sink stalls, the current word holds, the queue
// fills and then item_ready drops.
// ---------------------------------------------------------------------------
module fmp4_fragment_header_gen import fmp4h_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   mode,
	input  logic signed [PtsW-1:0] pts_ms,
	input  logic [31:0]            payload_len,
	input  logic                   is_key,
	output logic                   word_valid,
	input  logic                   word_ready,
	output logic [31:0]            header_word,
	output logic                   last_word
);

	cfg_t        cfg_q;
	reg_idx_t    reg_idx;
	logic        wr_en;
	logic        push;
	logic        push_ready;
	frag_entry_t push_entry;
	logic        q_valid;
	logic        q_pop;
	frag_entry_t q_entry;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_AUDIO_ENABLE: cfg_q.audio_enable <= pwdata[0];
				REG_AUDIO_RATE:   cfg_q.audio_rate   <= pwdata[RateW-1:0];
				REG_VIDEO_DUR:    cfg_q.video_dur    <= pwdata[DurRegW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_AUDIO_ENABLE: prdata = 32'(cfg_q.audio_enable);
			REG_AUDIO_RATE:   prdata = 32'(cfg_q.audio_rate);
			REG_VIDEO_DUR:    prdata = 32'(cfg_q.video_dur);
			default:          prdata = 32'd0;
		endcase
	end

	fmp4h_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.mode        (mode),
		.pts_ms      (pts_ms),
		.payload_len (payload_len),
		.is_key      (is_key),
		.push        (push),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	fmp4h_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_entry  (q_entry)
	);

	fmp4h_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.header_word (header_word),
		.last_word   (last_word)
	);

endmodule
